// ===== design/ris_pkg.sv =====
// ----------------------------------------------------------------------------
// Record insertion sorter package
// Field widths, arithmetic constants and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ris_pkg;

  localparam int MAX_RECORDS_DEF = 64;

  localparam int NAME_W  = 64;
  localparam int SCORE_W = 10;
  localparam int SUM_W   = 12;
  localparam int AVG_W   = 24;
  localparam int REC_W   = NAME_W + 3 * SCORE_W;
  localparam int IN_W    = 96;
  localparam int OUT_W   = 120;

  // sum * 10000 / 3 = sum * 3333 + sum / 3; (sum + 1) / 3 by reciprocal
  localparam int AVG_MUL_W  = 12;
  localparam int DIV3_MUL_W = 16;
  localparam logic [AVG_MUL_W-1:0]  AVG_MUL    = 12'd3333;
  localparam logic [DIV3_MUL_W-1:0] DIV3_MUL   = 16'd43691;
  localparam int                    DIV3_SHIFT = 17;

  typedef struct packed {
    logic cap;          // capture the incoming record
    logic rd_sel_emit;  // read address from the emit counter
    logic shift;        // move stored record up one slot
    logic place;        // write the new record at the insert position
    logic load_out;     // load the output register from the read data
    logic emit_next;    // advance the emit counter
    logic clear;        // empty the store
  } ctl_cmd_t;

  typedef struct packed {
    logic full;
    logic pos_zero;
    logic behind;
    logic fin;
    logic out_taken;
    logic out_last;
  } ctl_sts_t;

endpackage

// ===== design/ris_ctrl.sv =====
// ----------------------------------------------------------------------------
// Record insertion sorter controller
// Sequences capture, insertion by read-compare-shift, and sorted emission.
// ----------------------------------------------------------------------------
module ris_ctrl
  import ris_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd,
  output logic     in_ready
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS_CHK = 3'd1;
  localparam logic [2:0] ST_INS_CMP = 3'd2;
  localparam logic [2:0] ST_DONE    = 3'd3;
  localparam logic [2:0] ST_EMIT_RD = 3'd4;
  localparam logic [2:0] ST_EMIT_LD = 3'd5;
  localparam logic [2:0] ST_EMIT_WT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          state_next = ST_INS_CHK;
        end
      end
      ST_INS_CHK: begin
        // a full store drops the request
        if (sts.full) begin
          state_next = ST_DONE;
        end else if (sts.pos_zero) begin
          cmd.place  = 1'b1;
          state_next = ST_DONE;
        end else begin
          state_next = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts.behind) begin
          cmd.shift  = 1'b1;
          state_next = ST_INS_CHK;
        end else begin
          cmd.place  = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = sts.fin ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        cmd.rd_sel_emit = 1'b1;
        state_next      = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd.rd_sel_emit = 1'b1;
        cmd.load_out    = 1'b1;
        state_next      = ST_EMIT_WT;
      end
      ST_EMIT_WT: begin
        cmd.rd_sel_emit = 1'b1;
        if (sts.out_taken) begin
          if (sts.out_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/ris_datapath.sv =====
// ----------------------------------------------------------------------------
// Record insertion sorter datapath
// Record store, insert position, counters, key compare and output register.
// ----------------------------------------------------------------------------
module ris_datapath
  import ris_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  ctl_cmd_t         cmd,
  output ctl_sts_t         sts,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic [IN_W-1:0]  in_data,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data,
  output logic             out_last
);

  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);

  logic [REC_W-1:0] mem [MAX_RECORDS];
  logic [REC_W-1:0] rd_data;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [REC_W-1:0] wr_data;

  logic             sort_by_name;
  logic [REC_W-1:0] new_rec;
  logic [SUM_W-1:0] new_sum;
  logic             fin;
  logic [CW-1:0]    pos;
  logic [CW-1:0]    pos_m1;
  logic [CW-1:0]    count;
  logic [CW-1:0]    k;
  logic [CW-1:0]    k_p1;

  logic [REC_W-1:0] out_rec;
  logic [AVG_W-1:0] out_avg;

  logic [SUM_W-1:0] in_sum;
  logic [SUM_W-1:0] st_sum;
  logic             behind;

  logic [AVG_W-1:0]                  avg_main;
  logic [SUM_W+DIV3_MUL_W-1:0]       div3_prod;
  logic [SUM_W-1:0]                  sum_p1;
  logic [AVG_W-1:0]                  avg_calc;

  assign pos_m1  = pos - 1'b1;
  assign k_p1    = k + 1'b1;
  assign rd_addr = cmd.rd_sel_emit ? k[AW-1:0] : pos_m1[AW-1:0];
  assign wr_en   = cmd.shift | cmd.place;
  assign wr_data = cmd.shift ? rd_data : new_rec;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos[AW-1:0]] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign in_sum = SUM_W'(in_data[NAME_W +: SCORE_W])
                + SUM_W'(in_data[NAME_W + SCORE_W +: SCORE_W])
                + SUM_W'(in_data[NAME_W + 2 * SCORE_W +: SCORE_W]);

  assign st_sum = SUM_W'(rd_data[NAME_W +: SCORE_W])
                + SUM_W'(rd_data[NAME_W + SCORE_W +: SCORE_W])
                + SUM_W'(rd_data[NAME_W + 2 * SCORE_W +: SCORE_W]);

  // equal sums move behind; equal names stay ahead
  assign behind = sort_by_name ? (rd_data[NAME_W-1:0] > new_rec[NAME_W-1:0])
                               : (st_sum >= new_sum);

  assign sum_p1    = st_sum + 1'b1;
  assign avg_main  = AVG_W'(st_sum) * AVG_W'(AVG_MUL);
  assign div3_prod = sum_p1 * DIV3_MUL;
  assign avg_calc  = avg_main + AVG_W'(div3_prod[SUM_W+DIV3_MUL_W-1:DIV3_SHIFT]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_by_name <= 1'b0;
    end else if (cfg_we) begin
      sort_by_name <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      new_rec <= in_data[REC_W-1:0];
      new_sum <= in_sum;
      fin     <= in_last;
      pos     <= count;
    end else if (cmd.shift) begin
      pos <= pos_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      k     <= '0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
        k     <= '0;
      end else begin
        if (cmd.place) begin
          count <= count + 1'b1;
        end
        if (cmd.emit_next) begin
          k <= k_p1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rec  <= rd_data;
      out_avg  <= avg_calc;
      out_last <= (k_p1 == count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_data = {2'b00, out_avg, out_rec};

  assign sts.full      = (count == MAX_CNT);
  assign sts.pos_zero  = (pos == '0);
  assign sts.behind    = behind;
  assign sts.fin       = fin;
  assign sts.out_taken = out_valid & out_ready;
  assign sts.out_last  = out_last;

endmodule

// ===== design/record_insertion_sorter_top.sv =====
// ----------------------------------------------------------------------------
// Record insertion sorter
// Collects records into a sorted store and streams the sorted set out.
// ----------------------------------------------------------------------------
// Each accepted record is inserted into a store with one write port and one
// registered read port by walking down from the top: every held record that
// must move behind is read, compared and written up one slot, and the input
// is not ready again until the record is placed, or dropped when the store is
// full. A record that arrives with MAX_RECORDS held is dropped. After a record
// with s_tlast set, the whole set is streamed out in order, one record at a
// time, each read only after the one before it is taken, with m_tlast on the
// final one; the store is then empty. sort_by_name is written through
// cfg_we/cfg_wdata; the user must write it only while idle, the block does not enforce it.
module record_insertion_sorter_top
  import ris_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,    // sort_by_name
  input  logic             s_tvalid,
  output logic             s_tready,
  // name_bytes[63:0], first_score[73:64], second_score[83:74],
  // third_score[93:84], zero pad
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             s_tlast,      // final_record
  output logic             m_tvalid,
  input  logic             m_tready,
  // out_name[63:0], out_first[73:64], out_second[83:74], out_third[93:84],
  // average_scaled[117:94], zero pad
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast       // last_out
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  ris_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (s_tready)
  );

  ris_datapath #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

  // input is never taken while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready during emission");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.shift && cmd.place))
    else $error("shift and place in the same cycle");

  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> !sts.pos_zero)
    else $error("shift below the bottom slot");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not ready after the last result");

endmodule

// ===== tb/record_insertion_sorter_checker.sv =====
// ----------------------------------------------------------------------------
// Record insertion sorter checker
// Watches the configuration port and both stream channels, keeps its own
// sorted copy of the held records, and compares every sorted result that
// leaves the block with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module record_insertion_sorter_checker
  import ris_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             s_tlast,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  input  logic             m_tlast,
  output int               fail_count,
  output int               pending,
  output int               checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [SCORE_W-1:0] s1;
    logic [SCORE_W-1:0] s2;
    logic [SCORE_W-1:0] s3;
  } record_t;

  typedef struct packed {
    record_t          rec;
    logic [AVG_W-1:0] avg;
    logic             last;
  } sorted_result_t;

  record_t        held [MAX_RECORDS];
  int             held_count;
  logic           by_name;
  sorted_result_t sorted_due [$];

  function automatic logic [SUM_W-1:0] sum_of(record_t r);
    return {2'b00, r.s1} + {2'b00, r.s2} + {2'b00, r.s3};
  endfunction

  // true when the held record has to make room ahead of the new one
  function automatic logic goes_behind(record_t held_rec, record_t fresh);
    if (by_name)
      return held_rec.name > fresh.name;
    return sum_of(held_rec) >= sum_of(fresh);
  endfunction

  // (sum * 10000) / 3 rounded to nearest; a remainder of one half cannot occur
  function automatic logic [AVG_W-1:0] scaled_average(logic [SUM_W-1:0] s);
    logic [31:0] t;
    t = 32'(s) * 32'd10000 + 32'd1;
    return AVG_W'(t / 32'd3);
  endfunction

  task automatic report_mismatch(string msg);
    if (fail_count < PRINT_CAP)
      $display("[%0t] ERROR: %s", $time, msg);
    fail_count++;
  endtask

  task automatic take_record(record_t fresh, logic fin);
    int             pos;
    sorted_result_t r;
    // drop the record when the store is full; a final flag still flushes
    if (held_count < MAX_RECORDS) begin
      pos = held_count;
      while (pos > 0 && goes_behind(held[pos-1], fresh)) begin
        held[pos] = held[pos-1];
        pos--;
      end
      held[pos] = fresh;
      held_count++;
    end
    if (fin) begin
      for (int k = 0; k < held_count; k++) begin
        r.rec  = held[k];
        r.avg  = scaled_average(sum_of(held[k]));
        r.last = (k == held_count - 1);
        sorted_due.push_back(r);
      end
      held_count = 0;
    end
  endtask

  task automatic check_result();
    sorted_result_t want;
    record_t        got;
    logic [AVG_W-1:0] got_avg;
    got.name = m_tdata[63:0];
    got.s1   = m_tdata[73:64];
    got.s2   = m_tdata[83:74];
    got.s3   = m_tdata[93:84];
    got_avg  = m_tdata[117:94];
    if (sorted_due.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing outstanding (name %h)",
                                checked, got.name));
    end else begin
      want = sorted_due.pop_front();
      if (got.name !== want.rec.name)
        report_mismatch($sformatf("result %0d out_name %h, expected %h",
                                  checked, got.name, want.rec.name));
      if (got.s1 !== want.rec.s1)
        report_mismatch($sformatf("result %0d out_first %0d, expected %0d",
                                  checked, got.s1, want.rec.s1));
      if (got.s2 !== want.rec.s2)
        report_mismatch($sformatf("result %0d out_second %0d, expected %0d",
                                  checked, got.s2, want.rec.s2));
      if (got.s3 !== want.rec.s3)
        report_mismatch($sformatf("result %0d out_third %0d, expected %0d",
                                  checked, got.s3, want.rec.s3));
      if (got_avg !== want.avg)
        report_mismatch($sformatf("result %0d average_scaled %0d, expected %0d",
                                  checked, got_avg, want.avg));
      if (m_tlast !== want.last)
        report_mismatch($sformatf("result %0d last_out %b, expected %b",
                                  checked, m_tlast, want.last));
    end
    checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      by_name    = 1'b0;
      fail_count = 0;
      checked    = 0;
      sorted_due.delete();
    end else begin
      if (cfg_we)
        by_name = cfg_wdata;
      if (s_tvalid && s_tready)
        take_record({s_tdata[63:0], s_tdata[73:64], s_tdata[83:74], s_tdata[93:84]},
                    s_tlast);
      if (m_tvalid && m_tready)
        check_result();
    end
    pending <= sorted_due.size();
  end

endmodule

// ===== tb/record_insertion_sorter_top_tb.sv =====
// ----------------------------------------------------------------------------
// Record insertion sorter testbench
// Drives record sets in both sort orders, through directed corner cases and
// random sets under four idling mixes, with a long output hold-off and a
// full-store set; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module record_insertion_sorter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ris_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int CFG_PAUSE   = 140;
  localparam int END_WAIT    = 200;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 55;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic             cfg_wdata = 1'b0;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata   = '0;
  logic             s_tlast   = 1'b0;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  logic hold_done      = 1'b0;
  int   hold_left      = 0;
  int   quiet_cycles   = 0;
  int   records_sent   = 0;
  int   sets_sent      = 0;
  int   fail_count;
  int   pending;
  int   checked;

  int idle_mix  [4] = '{0, 72, 0, 25};
  int stall_mix [4] = '{0, 0, 72, 25};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  record_insertion_sorter_top #(
    .MAX_RECORDS(MAX_RECORDS_DEF)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  record_insertion_sorter_checker #(
    .MAX_RECORDS(MAX_RECORDS_DEF)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  // receiver: random stalls, or one long hold-off counted here when requested
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      if (hold_left == 0)
        hold_left = HOLD_CYCLES;
      hold_left--;
      m_tready <= 1'b0;
      if (hold_left == 0)
        hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // leaves valid high at the accepting edge; the caller decides what follows
  task automatic send_record(input logic [NAME_W-1:0] name, input logic [SCORE_W-1:0] a,
                             input logic [SCORE_W-1:0] b, input logic [SCORE_W-1:0] c,
                             input logic fin);
    s_tdata  <= {2'b00, c, b, a, name};
    s_tlast  <= fin;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    records_sent++;
    if (fin)
      sets_sent++;
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // let any insertion finish before touching the register
  task automatic write_mode(input logic by_name);
    s_tvalid <= 1'b0;
    repeat (CFG_PAUSE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= by_name;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [NAME_W-1:0] pick_name();
    logic [NAME_W-1:0] n;
    int                sel;
    sel = $urandom_range(9);
    n   = {$urandom, $urandom};
    if (sel == 6 || sel == 7) begin
      // small pool so that equal names meet in name order
      case ($urandom_range(3))
        0:       n = 64'h4142_4300_0000_0000;
        1:       n = 64'h4142_4344_0000_0000;
        2:       n = 64'h7A00_0000_0000_0000;
        default: n = 64'h0000_0000_0000_0001;
      endcase
    end else if (sel == 8) begin
      sel = $urandom_range(7);
      n   = (n >> (8 * sel)) << (8 * sel);
    end else if (sel == 9) begin
      n = $urandom_range(1) ? '1 : '0;
    end
    return n;
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score();
    case ($urandom_range(9))
      7:       return '0;
      8:       return '1;
      9:       return SCORE_W'(100 * $urandom_range(1, 3));
      default: return SCORE_W'($urandom_range(1023));
    endcase
  endfunction

  task automatic send_set(input int size);
    for (int i = 0; i < size; i++) begin
      send_record(pick_name(), pick_score(), pick_score(), pick_score(), i == size - 1);
      idle_gap();
    end
  endtask

  initial begin
    int target;
    int size;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_mode(1'b0);

    // average order: extremes, equal sums, rounding up
    send_record(64'h0, 10'd0, 10'd0, 10'd0, 1'b0);
    send_record('1, 10'd1023, 10'd1023, 10'd1023, 1'b0);
    send_record(64'h4100_0000_0000_0000, 10'd100, 10'd100, 10'd100, 1'b0);
    send_record(64'h4200_0000_0000_0000, 10'd300, 10'd0, 10'd0, 1'b0);
    send_record(64'h4300_0000_0000_0000, 10'd0, 10'd0, 10'd300, 1'b0);
    send_record(64'h4400_0000_0000_0000, 10'd1, 10'd1, 10'd0, 1'b1);
    drain();
    // a set of one record
    send_record(64'h5A5A_5A5A_5A5A_5A5A, 10'd512, 10'd511, 10'd1, 1'b1);
    drain();

    // name order: zero padding, equal names keep arrival order
    write_mode(1'b1);
    send_record(64'h6200_0000_0000_0000, 10'd1, 10'd2, 10'd3, 1'b0);
    send_record(64'h6162_0000_0000_0000, 10'd4, 10'd5, 10'd6, 1'b0);
    send_record('1, 10'd0, 10'd0, 10'd0, 1'b0);
    send_record(64'h0, 10'd1023, 10'd0, 10'd1023, 1'b0);
    send_record(64'h6162_0000_0000_0000, 10'd7, 10'd8, 10'd9, 1'b0);
    send_record(64'h0000_0000_0000_0001, 10'd10, 10'd11, 10'd12, 1'b1);
    drain();

    // switch order halfway through a set
    send_record(64'h7A00_0000_0000_0000, 10'd5, 10'd5, 10'd5, 1'b0);
    send_record(64'h6100_0000_0000_0000, 10'd900, 10'd900, 10'd900, 1'b0);
    write_mode(1'b0);
    send_record(64'h6D00_0000_0000_0000, 10'd10, 10'd10, 10'd10, 1'b0);
    send_record(64'h6E00_0000_0000_0000, 10'd0, 10'd0, 10'd0, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_mode(p % 2 == 0);
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      // hold the output back while sets keep coming, so the input stalls
      if (p == 0)
        hold_req <= 1'b1;
      // overfill the store: the last two records drop, the final flag still flushes
      if (p == 1)
        send_set(MAX_RECORDS_DEF + 2);
      target = records_sent + PHASE_ITEMS;
      while (records_sent < target) begin
        size = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        send_set(size);
      end
      drain();
      if (p == 0) begin
        while (!hold_done) @(posedge clk);
        hold_req <= 1'b0;
      end
    end

    repeat (END_WAIT) @(posedge clk);
    $display("Covered %0d records in %0d sets, %0d sorted results checked,", records_sent,
             sets_sent, checked);
    $display("both sort orders, a mid-set order change, a full store and four idling mixes.");
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
